>>> rtl/core/i2cms_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// Holds status codes, phase codes, error kinds and the state and result structs.
// No dependencies.
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int unsigned MAX_TRANSFER_LEN = 256;

    localparam int unsigned LEN_W   = 9;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned ERR_W   = 3;

    // Controller status codes.
    localparam logic [7:0] ST_NO_INFO    = 8'hF8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
    localparam logic [7:0] ST_DATAW_ACK  = 8'h28;
    localparam logic [7:0] ST_DATAW_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
    localparam logic [7:0] ST_DATAR_ACK  = 8'h50;
    localparam logic [7:0] ST_DATAR_NACK = 8'h58;

    // Transfer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SLAW    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATAW   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RESTART = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SLAR    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DATAR   = 3'd6;

    // Error kinds.
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_PROTOCOL   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_ADDR_W     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DATA_W     = 3'd3;
    localparam logic [ERR_W-1:0] ERR_ADDR_R     = 3'd4;
    localparam logic [ERR_W-1:0] ERR_EARLY_NACK = 3'd5;
    localparam logic [ERR_W-1:0] ERR_ARB        = 3'd6;

    // Start and acknowledge actions.
    localparam logic [1:0] START_NONE  = 2'd0;
    localparam logic [1:0] START_SET   = 2'd1;
    localparam logic [1:0] START_CLEAR = 2'd2;
    localparam logic [1:0] ACK_KEEP    = 2'd0;
    localparam logic [1:0] ACK_ACK     = 2'd1;
    localparam logic [1:0] ACK_NACK    = 2'd2;

    // Input item opcodes.
    localparam logic OP_ARM   = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_WRITE_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_READ_LENGTH   = 2'd2;

    localparam int unsigned OUT_BITS  = 37;
    localparam int unsigned OUT_TDATA = 40;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [ERR_W-1:0]   error_kind;
        logic [LEN_W-1:0]   write_remaining;
        logic [LEN_W-1:0]   read_remaining;
        logic [LEN_W-1:0]   bytes_read;
    } seq_state_t;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic [1:0]        start_action;
        logic              stop_request;
        logic [1:0]        ack_action;
        logic              write_taken;
        logic              received_valid;
        logic [BYTE_W-1:0] received_byte;
        logic              done_res;
        logic [ERR_W-1:0]  error_code;
        logic [LEN_W-1:0]  read_count;
    } seq_result_t;

    // Keeps the first error of a transfer.
    function automatic logic [ERR_W-1:0] note_error(input logic [ERR_W-1:0] cur,
                                                    input logic [ERR_W-1:0] kind);
        note_error = (cur == ERR_NONE) ? kind : cur;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [16:0] lim;
        lim = 17'(MAX_TRANSFER_LEN);
        clamp_len = ({8'd0, v} > lim) ? lim[LEN_W-1:0] : v;
    endfunction

endpackage

>>> rtl/core/i2cms_step.sv
// Next-state and result decode for one input word of the transfer sequencer.
// Purely combinational; depends on i2cms_pkg.
`timescale 1ns / 1ps

module i2cms_step (
    input  i2cms_pkg::seq_state_t  cur,
    input  logic                   op,
    input  logic [7:0]             status_code,
    input  logic [7:0]             rx_byte,
    input  logic [7:0]             next_write_byte,
    input  logic [6:0]             slave_address,
    input  logic [8:0]             write_length,
    input  logic [8:0]             read_length,
    output i2cms_pkg::seq_state_t  nxt,
    output i2cms_pkg::seq_result_t res
);
    import i2cms_pkg::*;

    logic                fail;
    logic [BYTE_W-1:0]   sla_w;
    logic [BYTE_W-1:0]   sla_r;

    assign sla_w = {slave_address, 1'b0};
    assign sla_r = {slave_address, 1'b1};

    always_comb begin
        nxt  = cur;
        fail = 1'b0;
        res  = '0;

        if (op == OP_ARM) begin
            nxt.error_kind      = ERR_NONE;
            nxt.write_remaining = clamp_len(write_length);
            nxt.read_remaining  = clamp_len(read_length);
            nxt.bytes_read      = '0;
            nxt.phase           = PH_START;
            res.start_action    = START_SET;
        end else begin
            case (status_code)
                ST_NO_INFO: begin
                end
                ST_START: begin
                    res.start_action = START_CLEAR;
                    if (cur.phase != PH_START) begin
                        fail = 1'b1;
                    end else if (cur.write_remaining != '0) begin
                        nxt.phase    = PH_SLAW;
                        res.tx_valid = 1'b1;
                        res.tx_byte  = sla_w;
                    end else begin
                        nxt.phase    = PH_SLAR;
                        res.tx_valid = 1'b1;
                        res.tx_byte  = sla_r;
                    end
                end
                ST_SLAW_ACK: begin
                    if (cur.phase == PH_SLAW) begin
                        nxt.phase       = PH_DATAW;
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = next_write_byte;
                        res.write_taken = 1'b1;
                        if (cur.write_remaining != '0) begin
                            nxt.write_remaining = cur.write_remaining - 9'd1;
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_SLAW_NACK: begin
                    if (cur.phase == PH_SLAW) begin
                        nxt.error_kind   = note_error(cur.error_kind, ERR_ADDR_W);
                        nxt.phase        = PH_IDLE;
                        res.stop_request = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_DATAW_ACK: begin
                    if (cur.phase != PH_DATAW) begin
                        fail = 1'b1;
                    end else if (cur.write_remaining != '0) begin
                        res.tx_valid        = 1'b1;
                        res.tx_byte         = next_write_byte;
                        res.write_taken     = 1'b1;
                        nxt.write_remaining = cur.write_remaining - 9'd1;
                    end else if (cur.read_remaining != '0) begin
                        nxt.phase        = PH_RESTART;
                        res.start_action = START_SET;
                    end else begin
                        nxt.phase        = PH_IDLE;
                        res.stop_request = 1'b1;
                    end
                end
                ST_DATAW_NACK: begin
                    if (cur.phase == PH_DATAW) begin
                        nxt.error_kind   = note_error(cur.error_kind, ERR_DATA_W);
                        nxt.phase        = PH_IDLE;
                        res.stop_request = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_RESTART: begin
                    res.start_action = START_CLEAR;
                    if (cur.phase == PH_RESTART) begin
                        nxt.phase    = PH_SLAR;
                        res.tx_valid = 1'b1;
                        res.tx_byte  = sla_r;
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_SLAR_ACK: begin
                    if (cur.phase == PH_SLAR) begin
                        nxt.phase      = PH_DATAR;
                        res.ack_action = (cur.read_remaining > 9'd1) ? ACK_ACK : ACK_NACK;
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_SLAR_NACK: begin
                    if (cur.phase == PH_SLAR) begin
                        nxt.error_kind   = note_error(cur.error_kind, ERR_ADDR_R);
                        nxt.phase        = PH_IDLE;
                        res.stop_request = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_DATAR_ACK, ST_DATAR_NACK: begin
                    if (cur.phase != PH_DATAR) begin
                        fail = 1'b1;
                    end else begin
                        res.received_valid = 1'b1;
                        res.received_byte  = rx_byte;
                        if (cur.bytes_read != '1) begin
                            nxt.bytes_read = cur.bytes_read + 9'd1;
                        end
                        // A byte beyond the expected count is still delivered.
                        if (cur.read_remaining != '0) begin
                            nxt.read_remaining = cur.read_remaining - 9'd1;
                            if (status_code == ST_DATAR_NACK &&
                                nxt.read_remaining != '0) begin
                                nxt.error_kind = note_error(cur.error_kind, ERR_EARLY_NACK);
                            end
                        end else begin
                            nxt.error_kind = note_error(cur.error_kind, ERR_PROTOCOL);
                        end
                        if (status_code == ST_DATAR_ACK) begin
                            if (nxt.read_remaining == 9'd1) begin
                                res.ack_action = ACK_NACK;
                            end
                        end else begin
                            nxt.phase        = PH_IDLE;
                            res.stop_request = 1'b1;
                        end
                    end
                end
                ST_ARB_LOST: begin
                    nxt.error_kind   = note_error(cur.error_kind, ERR_ARB);
                    nxt.phase        = PH_IDLE;
                    res.stop_request = 1'b1;
                end
                default: begin
                    fail = 1'b1;
                end
            endcase

            if (fail) begin
                nxt.error_kind   = note_error(nxt.error_kind, ERR_PROTOCOL);
                nxt.phase        = PH_IDLE;
                res.stop_request = 1'b1;
            end
        end

        res.done_res   = (nxt.phase == PH_IDLE);
        res.error_code = nxt.error_kind;
        res.read_count = nxt.bytes_read;
    end

endmodule

>>> rtl/core/i2c_master_transfer_sequencer.sv
// Top level of the I2C master write-then-read transfer sequencer.
// Each result word is registered and appears on m_tdata in the cycle after its input word is accepted.
// Throughput: one input word per cycle; s_tready drops only while a result waits.
// Reset (aresetn low, synchronous) idles the phase, clears the counters, the error
// kind and the configuration registers, and clears the result valid flag (m_tdata is not reset).
// Depends on i2cms_pkg and i2cms_step.
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // status_code[7:0], rx_byte[15:8], next_write_byte[23:16]
    input  logic        s_tuser,  // op
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_valid[0], tx_byte[8:1], start_action[10:9], stop_request[11],
    // ack_action[13:12], write_taken[14], received_valid[15], received_byte[23:16],
    // done_res[24], error_code[27:25], read_count[36:28], zero fill[39:37]
    output logic [39:0] m_tdata
);
    import i2cms_pkg::*;

    logic [ADDR_W-1:0]       slave_address_reg;
    logic [LEN_W-1:0]        write_length_reg;
    logic [LEN_W-1:0]        read_length_reg;
    seq_state_t              state_reg;
    seq_state_t              state_next;
    seq_result_t             res_next;
    logic                    out_valid_reg;
    logic [OUT_TDATA-1:0]    out_data_reg;
    logic                    accept;
    logic [OUT_BITS-1:0]     res_bits;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2cms_step u_step (
        .cur             (state_reg),
        .op              (s_tuser),
        .status_code     (s_tdata[7:0]),
        .rx_byte         (s_tdata[15:8]),
        .next_write_byte (s_tdata[23:16]),
        .slave_address   (slave_address_reg),
        .write_length    (write_length_reg),
        .read_length     (read_length_reg),
        .nxt             (state_next),
        .res             (res_next)
    );

    assign res_bits = {res_next.read_count, res_next.error_code, res_next.done_res,
                       res_next.received_byte, res_next.received_valid,
                       res_next.write_taken, res_next.ack_action, res_next.stop_request,
                       res_next.start_action, res_next.tx_byte, res_next.tx_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= '0;
            write_length_reg  <= '0;
            read_length_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_wdata[ADDR_W-1:0];
                CFG_WRITE_LENGTH:  write_length_reg  <= cfg_wdata;
                CFG_READ_LENGTH:   read_length_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase           <= PH_IDLE;
            state_reg.error_kind      <= ERR_NONE;
            state_reg.write_remaining <= '0;
            state_reg.read_remaining  <= '0;
            state_reg.bytes_read      <= '0;
            out_valid_reg             <= 1'b0;
        end else begin
            if (accept) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {{(OUT_TDATA - OUT_BITS){1'b0}}, res_bits};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
